@@ src/sbt_pkg.sv @@
`default_nettype none
package sbt_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int FIELD_BITS = 16;

  localparam logic [5:0] TT_NONE    = 6'd0;
  localparam logic [5:0] TT_END     = 6'd0;
  localparam logic [5:0] TT_CLN     = 6'd1;
  localparam logic [5:0] TT_SEMI    = 6'd2;
  localparam logic [5:0] TT_QUEST   = 6'd3;
  localparam logic [5:0] TT_LPAR    = 6'd4;
  localparam logic [5:0] TT_RPAR    = 6'd5;
  localparam logic [5:0] TT_ASSIGN  = 6'd6;
  localparam logic [5:0] TT_EQ      = 6'd7;
  localparam logic [5:0] TT_BOR     = 6'd8;
  localparam logic [5:0] TT_LOR     = 6'd9;
  localparam logic [5:0] TT_BAND    = 6'd10;
  localparam logic [5:0] TT_LAND    = 6'd11;
  localparam logic [5:0] TT_XOR     = 6'd12;
  localparam logic [5:0] TT_NOT     = 6'd13;
  localparam logic [5:0] TT_NE      = 6'd14;
  localparam logic [5:0] TT_LT      = 6'd15;
  localparam logic [5:0] TT_LE      = 6'd16;
  localparam logic [5:0] TT_SHL     = 6'd17;
  localparam logic [5:0] TT_GT      = 6'd18;
  localparam logic [5:0] TT_GE      = 6'd19;
  localparam logic [5:0] TT_SHR     = 6'd20;
  localparam logic [5:0] TT_PLUS    = 6'd21;
  localparam logic [5:0] TT_INC     = 6'd22;
  localparam logic [5:0] TT_SUB     = 6'd23;
  localparam logic [5:0] TT_DEC     = 6'd24;
  localparam logic [5:0] TT_STAR    = 6'd25;
  localparam logic [5:0] TT_SLASH   = 6'd26;
  localparam logic [5:0] TT_PERCENT = 6'd27;
  localparam logic [5:0] TT_BITNOT  = 6'd28;
  localparam logic [5:0] TT_IDENT   = 6'd29;
  localparam logic [5:0] TT_INT     = 6'd30;
  localparam logic [5:0] TT_KW_VAR  = 6'd31;
  localparam logic [5:0] TT_KW_IF   = 6'd32;
  localparam logic [5:0] TT_KW_ELSE = 6'd33;
  localparam logic [5:0] TT_KW_GOTO = 6'd34;
  localparam logic [5:0] TT_KW_PRINT = 6'd35;
  localparam logic [5:0] TT_ERROR   = 6'd36;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_UNDER   = "_";

  typedef enum logic [2:0] {
    CL_SPACE,
    CL_SINGLE,
    CL_PAIR,
    CL_ALPHA,
    CL_DIGIT,
    CL_UNDER,
    CL_OTHER
  } cls_t;

  typedef struct packed {
    logic       eos;
    cls_t       cls;
    logic [5:0] op;
    logic [7:0] chr;
  } item_t;

  typedef struct packed {
    logic [5:0]            ttype;
    logic [FIELD_BITS-1:0] sidx;
    logic [FIELD_BITS-1:0] sline;
    logic [FIELD_BITS-1:0] scol;
    logic [FIELD_BITS-1:0] eidx;
    logic                  last;
  } tok_t;

  typedef logic [4:0][7:0] word_t;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c = CL_OTHER;
    if (b inside {8'h20, [8'h09:8'h0D]}) c = CL_SPACE;
    else if (b inside {":", ";", "?", "(", ")", "^", "*", "/", "%", "~"}) c = CL_SINGLE;
    else if (b inside {"=", "|", "&", "!", "<", ">", "+", "-"}) c = CL_PAIR;
    else if (b inside {["a":"z"], ["A":"Z"]}) c = CL_ALPHA;
    else if (b inside {["0":"9"]}) c = CL_DIGIT;
    else if (b == CH_UNDER) c = CL_UNDER;
    return c;
  endfunction

  function automatic logic [5:0] op_code(input logic [7:0] b);
    logic [5:0] t;
    case (b)
      ":":     t = TT_CLN;
      ";":     t = TT_SEMI;
      "?":     t = TT_QUEST;
      "(":     t = TT_LPAR;
      ")":     t = TT_RPAR;
      "^":     t = TT_XOR;
      "*":     t = TT_STAR;
      "/":     t = TT_SLASH;
      "%":     t = TT_PERCENT;
      "~":     t = TT_BITNOT;
      "=":     t = TT_ASSIGN;
      "|":     t = TT_BOR;
      "&":     t = TT_BAND;
      "!":     t = TT_NOT;
      "<":     t = TT_LT;
      ">":     t = TT_GT;
      "+":     t = TT_PLUS;
      "-":     t = TT_SUB;
      default: t = TT_NONE;
    endcase
    return t;
  endfunction

  function automatic logic [5:0] pair_second(input logic [5:0] first, input logic [7:0] b);
    logic [5:0] t;
    t = TT_NONE;
    case (first)
      TT_ASSIGN: if (b == "=") t = TT_EQ;
      TT_BOR:    if (b == "|") t = TT_LOR;
      TT_BAND:   if (b == "&") t = TT_LAND;
      TT_NOT:    if (b == "=") t = TT_NE;
      TT_LT:     if (b == "=") t = TT_LE; else if (b == "<") t = TT_SHL;
      TT_GT:     if (b == "=") t = TT_GE; else if (b == ">") t = TT_SHR;
      TT_PLUS:   if (b == "+") t = TT_INC;
      TT_SUB:    if (b == "-") t = TT_DEC;
      default:   t = TT_NONE;
    endcase
    return t;
  endfunction

  function automatic logic [5:0] word_type(input word_t w, input logic [2:0] len);
    logic [5:0] t;
    t = TT_IDENT;
    if (len == 3'd3 && w[0] == "v" && w[1] == "a" && w[2] == "r") t = TT_KW_VAR;
    else if (len == 3'd2 && w[0] == "i" && w[1] == "f") t = TT_KW_IF;
    else if (len == 3'd4 && w[0] == "e" && w[1] == "l" && w[2] == "s" && w[3] == "e")
      t = TT_KW_ELSE;
    else if (len == 3'd4 && w[0] == "g" && w[1] == "o" && w[2] == "t" && w[3] == "o")
      t = TT_KW_GOTO;
    else if (len == 3'd5 && w[0] == "p" && w[1] == "r" && w[2] == "i" && w[3] == "n" &&
             w[4] == "t")
      t = TT_KW_PRINT;
    return t;
  endfunction

endpackage
`default_nettype wire

@@ src/source_byte_tokenizer_core.sv @@
// Path: each byte is stored in the byte queue; its tokens leave through the output register.
// Throughput: one byte per cycle while the output is taken; a byte that closes two
// tokens (a flush plus a new token, or a flush plus the end token) holds the lexer
// while the spill slot drains through the output register.
// Reset: synchronous, active high; clears the byte queue and the lexer state (not the word and token data registers).
`default_nettype none
module source_byte_tokenizer_core #(
  parameter int POSITION_BITS = sbt_pkg::POSITION_BITS_DEFAULT,
  parameter int QUEUE_DEPTH   = sbt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] byte_req
  input  wire logic        s_tuser,  // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,  // [5:0] type, [21:6] start_index,
                                     // [37:22] start_line, [53:38] start_column,
                                     // [69:54] end_index, [71:70] zero
  output logic             m_tlast   // last
);

  localparam int IW = $bits(sbt_pkg::item_t);

  logic           q_full;
  logic           q_wr;
  sbt_pkg::item_t q_wr_item;
  logic           q_rd;
  logic           q_valid;
  logic [IW-1:0]  q_rd_data;
  sbt_pkg::item_t q_rd_item;
  sbt_pkg::tok_t  tok;

  sbt_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_item   (q_wr_item)
  );

  sbt_queue #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_data  (q_wr_item),
    .full     (q_full),
    .rd_en    (q_rd),
    .rd_data  (q_rd_data),
    .rd_valid (q_valid)
  );

  assign q_rd_item = sbt_pkg::item_t'(q_rd_data);

  sbt_lexer #(
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_rd_item),
    .q_rd     (q_rd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tok    (tok)
  );

  assign m_tdata = {2'b00, tok.eidx, tok.scol, tok.sline, tok.sidx, tok.ttype};
  assign m_tlast = tok.last;

endmodule
`default_nettype wire

@@ src/sbt_queue.sv @@
`default_nettype none
module sbt_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  rd_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == FULL_COUNT);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/sbt_front.sv @@
`default_nettype none
module sbt_front (
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       s_tuser,
  input  wire logic       q_full,
  output logic            q_wr,
  output sbt_pkg::item_t  q_item
);

  assign s_tready = !q_full;
  assign q_wr     = s_tvalid && !q_full;

  always_comb begin
    q_item.eos = s_tuser || (s_tdata == 8'h00);
    q_item.cls = sbt_pkg::classify(s_tdata);
    q_item.op  = sbt_pkg::op_code(s_tdata);
    q_item.chr = s_tdata;
  end

endmodule
`default_nettype wire

@@ src/sbt_lexer.sv @@
`default_nettype none
module sbt_lexer #(
  parameter int POSITION_BITS = sbt_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire sbt_pkg::item_t  q_item,
  output logic                 q_rd,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output sbt_pkg::tok_t        m_tok
);

  localparam int PB = POSITION_BITS;
  localparam logic [PB-1:0] POS_MAX = '1;
  localparam logic [PB-1:0] POS_ONE = PB'(1);

  logic [5:0]     pend;
  logic [PB-1:0]  tok_idx, tok_line, tok_col;
  logic [PB-1:0]  cur_idx, cur_line, cur_col;
  sbt_pkg::word_t word_chars;
  logic [2:0]     word_length;
  logic           halted;

  logic [5:0]     pend_next;
  logic [PB-1:0]  tok_idx_next, tok_line_next, tok_col_next;
  logic [PB-1:0]  cur_idx_next, cur_line_next, cur_col_next;
  sbt_pkg::word_t word_chars_next;
  logic [2:0]     word_length_next;
  logic           halted_next;

  logic           out_valid;
  logic           spill_valid;
  sbt_pkg::tok_t  spill_tok;
  logic           out_free;

  logic           f_valid, g_valid;
  sbt_pkg::tok_t  f_tok, g_tok;

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic sbt_pkg::tok_t mk_tok(input logic [5:0] t, input logic [PB-1:0] si,
                                           input logic [PB-1:0] sl, input logic [PB-1:0] sc,
                                           input logic [PB-1:0] ei);
    sbt_pkg::tok_t r;
    r.ttype = t;
    r.sidx  = sbt_pkg::FIELD_BITS'(si);
    r.sline = sbt_pkg::FIELD_BITS'(sl);
    r.scol  = sbt_pkg::FIELD_BITS'(sc);
    r.eidx  = sbt_pkg::FIELD_BITS'(ei);
    r.last  = 1'b0;
    return r;
  endfunction

  assign out_free = !out_valid || m_tready;
  assign q_rd     = q_valid && !spill_valid && out_free;
  assign m_tvalid = out_valid;

  always_comb begin
    logic [PB-1:0] adv_idx, adv_line, adv_col;
    logic [5:0]    flush_t, sec;
    logic          is_nl, cont_word, do_flush, done;
    sbt_pkg::cls_t c;

    pend_next        = pend;
    tok_idx_next     = tok_idx;
    tok_line_next    = tok_line;
    tok_col_next     = tok_col;
    cur_idx_next     = cur_idx;
    cur_line_next    = cur_line;
    cur_col_next     = cur_col;
    word_chars_next  = word_chars;
    word_length_next = word_length;
    halted_next      = halted;
    f_valid = 1'b0;
    g_valid = 1'b0;
    f_tok   = '0;
    g_tok   = '0;

    c         = q_item.cls;
    is_nl     = (q_item.chr == sbt_pkg::CH_NEWLINE);
    adv_idx   = sat_inc(cur_idx);
    adv_line  = is_nl ? sat_inc(cur_line) : cur_line;
    adv_col   = is_nl ? POS_ONE : sat_inc(cur_col);
    flush_t   = (pend == sbt_pkg::TT_IDENT) ? sbt_pkg::word_type(word_chars, word_length)
                                            : pend;
    cont_word = (c == sbt_pkg::CL_ALPHA) || (c == sbt_pkg::CL_DIGIT) ||
                (c == sbt_pkg::CL_UNDER);
    sec       = sbt_pkg::pair_second(pend, q_item.chr);
    do_flush  = 1'b0;
    done      = 1'b0;

    if (q_item.eos) begin
      if (pend != sbt_pkg::TT_NONE) begin
        f_valid = 1'b1;
        f_tok   = mk_tok(flush_t, tok_idx, tok_line, tok_col, cur_idx);
      end
      g_valid = 1'b1;
      g_tok   = mk_tok(sbt_pkg::TT_END, cur_idx, cur_line, cur_col, cur_idx);
      pend_next        = sbt_pkg::TT_NONE;
      tok_idx_next     = '0;
      tok_line_next    = POS_ONE;
      tok_col_next     = POS_ONE;
      cur_idx_next     = '0;
      cur_line_next    = POS_ONE;
      cur_col_next     = POS_ONE;
      word_length_next = '0;
      halted_next      = 1'b0;
    end else if (!halted) begin
      if (pend == sbt_pkg::TT_IDENT) begin
        if (cont_word) begin
          for (int i = 0; i < 5; i++) begin
            if (word_length == 3'(i)) word_chars_next[i] = q_item.chr;
          end
          if (word_length < 3'd6) word_length_next = word_length + 1'b1;
          done = 1'b1;
        end else begin
          do_flush = 1'b1;
        end
      end else if (pend == sbt_pkg::TT_INT) begin
        if (c == sbt_pkg::CL_DIGIT) done = 1'b1;
        else do_flush = 1'b1;
      end else if (pend != sbt_pkg::TT_NONE) begin
        if (sec != sbt_pkg::TT_NONE) begin
          g_valid   = 1'b1;
          g_tok     = mk_tok(sec, tok_idx, tok_line, tok_col, adv_idx);
          pend_next = sbt_pkg::TT_NONE;
          done      = 1'b1;
        end else begin
          do_flush = 1'b1;
        end
      end

      cur_idx_next  = adv_idx;
      cur_line_next = adv_line;
      cur_col_next  = adv_col;

      if (do_flush) begin
        f_valid          = 1'b1;
        f_tok            = mk_tok(flush_t, tok_idx, tok_line, tok_col, cur_idx);
        pend_next        = sbt_pkg::TT_NONE;
        word_length_next = '0;
      end

      if (!done) begin
        tok_idx_next  = cur_idx;
        tok_line_next = cur_line;
        tok_col_next  = cur_col;
        case (c)
          sbt_pkg::CL_SPACE: ;
          sbt_pkg::CL_SINGLE: begin
            g_valid = 1'b1;
            g_tok   = mk_tok(q_item.op, cur_idx, cur_line, cur_col, adv_idx);
          end
          sbt_pkg::CL_PAIR: pend_next = q_item.op;
          sbt_pkg::CL_ALPHA, sbt_pkg::CL_UNDER: begin
            pend_next          = sbt_pkg::TT_IDENT;
            word_chars_next[0] = q_item.chr;
            word_length_next   = 3'd1;
          end
          sbt_pkg::CL_DIGIT: pend_next = sbt_pkg::TT_INT;
          default: begin
            g_valid     = 1'b1;
            g_tok       = mk_tok(sbt_pkg::TT_ERROR, cur_idx, cur_line, cur_col, adv_idx);
            halted_next = 1'b1;
          end
        endcase
      end
    end

    if (g_valid) g_tok.last = 1'b1;
    else if (f_valid) f_tok.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      word_chars <= word_chars_next;
    end
    if (spill_valid && out_free) begin
      m_tok <= spill_tok;
    end else if (q_rd) begin
      if (f_valid) m_tok <= f_tok;
      else if (g_valid) m_tok <= g_tok;
      if (f_valid && g_valid) spill_tok <= g_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= sbt_pkg::TT_NONE;
      tok_idx     <= '0;
      tok_line    <= POS_ONE;
      tok_col     <= POS_ONE;
      cur_idx     <= '0;
      cur_line    <= POS_ONE;
      cur_col     <= POS_ONE;
      word_length <= '0;
      halted      <= 1'b0;
      out_valid   <= 1'b0;
      spill_valid <= 1'b0;
    end else begin
      if (q_rd) begin
        pend        <= pend_next;
        tok_idx     <= tok_idx_next;
        tok_line    <= tok_line_next;
        tok_col     <= tok_col_next;
        cur_idx     <= cur_idx_next;
        cur_line    <= cur_line_next;
        cur_col     <= cur_col_next;
        word_length <= word_length_next;
        halted      <= halted_next;
      end
      if (spill_valid && out_free) begin
        out_valid   <= 1'b1;
        spill_valid <= 1'b0;
      end else if (q_rd && (f_valid || g_valid)) begin
        out_valid   <= 1'b1;
        spill_valid <= f_valid && g_valid;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;  // [7:0] byte_req
  logic        s_tuser = 1'b0;   // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;          // [5:0] type, [21:6] start index, [37:22] start line,
                                 // [53:38] start column, [69:54] end index, [71:70] zero
  logic        m_tlast;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  bit rx_hold = 1'b0;
  int fail_cnt = 0;
  int fed_items = 0;
  int tokens_checked = 0;
  int sources_seen = 0;

  sbt_pkg::tok_t tok_q[$];

  // lexer shadow state
  logic [5:0]  pend_tt;
  logic [15:0] tok_idx, tok_line, tok_col;
  logic [15:0] cur_idx, cur_line, cur_col;
  logic [7:0]  wbuf [5];
  int          wlen;
  bit          halted;

  string kw_words [10] = '{"var", "if", "else", "goto", "print",
                           "va", "iff", "elsex", "got", "prints"};
  string op_words [28] = '{":", ";", "?", "(", ")", "^", "*", "/", "%", "~",
                           "=", "==", "|", "||", "&", "&&", "!", "!=",
                           "<", "<=", "<<", ">", ">=", ">>", "+", "++", "-", "--"};

  source_byte_tokenizer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= !rx_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == " " || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [5:0] single_code(input logic [7:0] b);
    case (b)
      ":": return sbt_pkg::TT_CLN;
      ";": return sbt_pkg::TT_SEMI;
      "?": return sbt_pkg::TT_QUEST;
      "(": return sbt_pkg::TT_LPAR;
      ")": return sbt_pkg::TT_RPAR;
      "^": return sbt_pkg::TT_XOR;
      "*": return sbt_pkg::TT_STAR;
      "/": return sbt_pkg::TT_SLASH;
      "%": return sbt_pkg::TT_PERCENT;
      "~": return sbt_pkg::TT_BITNOT;
      default: return sbt_pkg::TT_NONE;
    endcase
  endfunction

  function automatic logic [5:0] pair_open(input logic [7:0] b);
    case (b)
      "=": return sbt_pkg::TT_ASSIGN;
      "|": return sbt_pkg::TT_BOR;
      "&": return sbt_pkg::TT_BAND;
      "!": return sbt_pkg::TT_NOT;
      "<": return sbt_pkg::TT_LT;
      ">": return sbt_pkg::TT_GT;
      "+": return sbt_pkg::TT_PLUS;
      "-": return sbt_pkg::TT_SUB;
      default: return sbt_pkg::TT_NONE;
    endcase
  endfunction

  function automatic logic [5:0] pair_close(input logic [5:0] head, input logic [7:0] b);
    case (head)
      sbt_pkg::TT_ASSIGN: return (b == "=") ? sbt_pkg::TT_EQ : sbt_pkg::TT_NONE;
      sbt_pkg::TT_BOR:    return (b == "|") ? sbt_pkg::TT_LOR : sbt_pkg::TT_NONE;
      sbt_pkg::TT_BAND:   return (b == "&") ? sbt_pkg::TT_LAND : sbt_pkg::TT_NONE;
      sbt_pkg::TT_NOT:    return (b == "=") ? sbt_pkg::TT_NE : sbt_pkg::TT_NONE;
      sbt_pkg::TT_LT:     return (b == "=") ? sbt_pkg::TT_LE :
                                 ((b == "<") ? sbt_pkg::TT_SHL : sbt_pkg::TT_NONE);
      sbt_pkg::TT_GT:     return (b == "=") ? sbt_pkg::TT_GE :
                                 ((b == ">") ? sbt_pkg::TT_SHR : sbt_pkg::TT_NONE);
      sbt_pkg::TT_PLUS:   return (b == "+") ? sbt_pkg::TT_INC : sbt_pkg::TT_NONE;
      sbt_pkg::TT_SUB:    return (b == "-") ? sbt_pkg::TT_DEC : sbt_pkg::TT_NONE;
      default:            return sbt_pkg::TT_NONE;
    endcase
  endfunction

  function automatic logic [5:0] keyword_of();
    logic [39:0] w;
    w = '0;
    if (wlen > 5) return sbt_pkg::TT_IDENT;
    for (int i = 0; i < wlen; i++) w = {w[31:0], wbuf[i]};
    if (wlen == 3 && w == "var") return sbt_pkg::TT_KW_VAR;
    if (wlen == 2 && w == "if") return sbt_pkg::TT_KW_IF;
    if (wlen == 4 && w == "else") return sbt_pkg::TT_KW_ELSE;
    if (wlen == 4 && w == "goto") return sbt_pkg::TT_KW_GOTO;
    if (wlen == 5 && w == "print") return sbt_pkg::TT_KW_PRINT;
    return sbt_pkg::TT_IDENT;
  endfunction

  function automatic void lexer_clear();
    pend_tt = sbt_pkg::TT_NONE;
    tok_idx = 16'd0;
    tok_line = 16'd1;
    tok_col = 16'd1;
    cur_idx = 16'd0;
    cur_line = 16'd1;
    cur_col = 16'd1;
    wlen = 0;
    halted = 1'b0;
  endfunction

  function automatic void step_cursor(input logic [7:0] b);
    if (b == sbt_pkg::CH_NEWLINE) begin
      cur_line = bump(cur_line);
      cur_col = 16'd1;
    end else begin
      cur_col = bump(cur_col);
    end
    cur_idx = bump(cur_idx);
  endfunction

  function automatic void mark_start();
    tok_idx = cur_idx;
    tok_line = cur_line;
    tok_col = cur_col;
  endfunction

  function automatic void push_token(input logic [5:0] tt, input logic [15:0] e);
    sbt_pkg::tok_t t;
    t.ttype = tt;
    t.sidx = tok_idx;
    t.sline = tok_line;
    t.scol = tok_col;
    t.eidx = e;
    t.last = 1'b0;
    tok_q.push_back(t);
  endfunction

  function automatic void flush_pending();
    if (pend_tt == sbt_pkg::TT_NONE) return;
    push_token((pend_tt == sbt_pkg::TT_IDENT) ? keyword_of() : pend_tt, cur_idx);
    pend_tt = sbt_pkg::TT_NONE;
    wlen = 0;
  endfunction

  function automatic void lex_byte(input logic k, input logic [7:0] b);
    int base;
    logic [5:0] t;
    base = tok_q.size();
    if (k || b == 8'h00) begin
      flush_pending();
      mark_start();
      push_token(sbt_pkg::TT_END, cur_idx);
      lexer_clear();
    end else if (!halted) begin
      if (pend_tt == sbt_pkg::TT_IDENT &&
          (is_letter(b) || is_digit(b) || b == sbt_pkg::CH_UNDER)) begin
        if (wlen < 5) wbuf[wlen] = b;
        if (wlen < 6) wlen++;
        step_cursor(b);
      end else if (pend_tt == sbt_pkg::TT_INT && is_digit(b)) begin
        step_cursor(b);
      end else if (pair_close(pend_tt, b) != sbt_pkg::TT_NONE) begin
        t = pair_close(pend_tt, b);
        step_cursor(b);
        push_token(t, cur_idx);
        pend_tt = sbt_pkg::TT_NONE;
      end else begin
        flush_pending();
        mark_start();
        if (is_blank(b)) begin
          step_cursor(b);
        end else if (single_code(b) != sbt_pkg::TT_NONE) begin
          step_cursor(b);
          push_token(single_code(b), cur_idx);
        end else if (pair_open(b) != sbt_pkg::TT_NONE) begin
          pend_tt = pair_open(b);
          step_cursor(b);
        end else if (is_letter(b) || b == sbt_pkg::CH_UNDER) begin
          pend_tt = sbt_pkg::TT_IDENT;
          wbuf[0] = b;
          wlen = 1;
          step_cursor(b);
        end else if (is_digit(b)) begin
          pend_tt = sbt_pkg::TT_INT;
          step_cursor(b);
        end else begin
          step_cursor(b);
          push_token(sbt_pkg::TT_ERROR, cur_idx);
          halted = 1'b1;
        end
      end
    end
    if (tok_q.size() > base) tok_q[tok_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) lex_byte(s_tuser, s_tdata);
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin : check_tokens
    sbt_pkg::tok_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tok_q.size() == 0) begin
        $error("unexpected token: type %0d, start index %0d", m_tdata[5:0], m_tdata[21:6]);
        fail_cnt++;
      end else begin
        want = tok_q.pop_front();
        check_field("type", want.ttype, m_tdata[5:0]);
        check_field("start_index", want.sidx, m_tdata[21:6]);
        check_field("start_line", want.sline, m_tdata[37:22]);
        check_field("start_column", want.scol, m_tdata[53:38]);
        check_field("end_index", want.eidx, m_tdata[69:54]);
        check_field("pad", 0, m_tdata[71:70]);
        check_field("last", want.last, m_tlast);
        tokens_checked++;
        if (want.ttype == sbt_pkg::TT_END) sources_seen++;
      end
    end
  end

  task automatic send_byte(input logic k, input logic [7:0] b);
    int gap;
    fed_items++;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(1'b0, s[i]);
  endtask

  function automatic logic [7:0] word_byte(input bit lead);
    int r;
    r = $urandom_range(lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return sbt_pkg::CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? 8'h20 : 8'(8'h09 + r);
  endfunction

  task automatic send_fragment();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_text(kw_words[$urandom_range(9)]);
    end else if (pick < 35) begin
      len = $urandom_range(1, 9);
      send_byte(1'b0, word_byte(1'b1));
      repeat (len - 1) send_byte(1'b0, word_byte(1'b0));
    end else if (pick < 50) begin
      len = $urandom_range(1, 6);
      repeat (len) send_byte(1'b0, 8'("0" + $urandom_range(9)));
    end else if (pick < 85) begin
      send_text(op_words[$urandom_range(27)]);
    end else if (pick < 96) begin
      send_byte(1'b0, blank_byte());
    end else begin
      send_byte(1'b0, 8'($urandom_range(1, 255)));
    end
    if ($urandom_range(1)) send_byte(1'b0, blank_byte());
  endtask

  task automatic test_directed();
    send_text("if else\tprint5 >>=<\n_9 ");
    send_byte(1'b0, 8'hFF);  // error, lexer halts
    send_byte(1'b0, "a");    // dropped while halted
    send_byte(1'b1, 8'hAA);  // end of source, data ignored
    send_text("go");
    send_byte(1'b0, 8'h00);  // zero byte also ends the source
  endtask

  task automatic test_random_sources(input int budget);
    int goal;
    int n_frag;
    goal = fed_items + budget;
    while (fed_items < goal) begin
      n_frag = $urandom_range(1, 16);
      repeat (n_frag) send_fragment();
      if ($urandom_range(1)) send_byte(1'b1, 8'($urandom_range(255)));
      else send_byte(1'b0, 8'h00);
    end
  endtask

  task automatic test_output_stall();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    // ident followed by ';' gives two tokens from each ';' byte
    repeat (30) begin
      send_byte(1'b0, "a");
      send_byte(1'b0, ";");
    end
    send_byte(1'b1, 8'h00);
  endtask

  initial begin
    lexer_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 36;
    sink_idle_pct = 56;
    test_directed();
    test_random_sources(500);
    src_idle_pct = 56;
    sink_idle_pct = 36;
    test_random_sources(500);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_sources(500);
    test_output_stall();
    s_tvalid <= 1'b0;
    while (tok_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d items over %0d sources, %0d tokens compared", fed_items,
             sources_seen, tokens_checked);
    $display("keywords, operators, errors, zero-byte ends, idle mixes, output stalls");
    if (fail_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
src/sbt_pkg.sv
src/sbt_queue.sv
src/sbt_front.sv
src/sbt_lexer.sv
src/source_byte_tokenizer_core.sv
tb/testbench.sv
